@@ hdl/tdl_pkg.sv @@
// shared types, token codes and keyword table for the table-driven lexer
package tdl_pkg;

	// field widths
	localparam int CHAR_W = 8;
	localparam int KIND_W = 6;
	localparam int ERR_W  = 2;
	localparam int LINE_W = 16;
	localparam int LEN_W  = 6;
	localparam int OUT_W  = 32;

	// defaults for top-level parameters and register reset
	localparam int KEYWORD_CHARS_DEF = 10;
	localparam int LINE_BITS_DEF     = 16;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd30;

	// token codes
	localparam logic [KIND_W-1:0] K_ADD      = 6'd0;
	localparam logic [KIND_W-1:0] K_SUB      = 6'd1;
	localparam logic [KIND_W-1:0] K_MUL      = 6'd2;
	localparam logic [KIND_W-1:0] K_DIV      = 6'd3;
	localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd4;
	localparam logic [KIND_W-1:0] K_EQUAL    = 6'd5;
	localparam logic [KIND_W-1:0] K_LT       = 6'd6;
	localparam logic [KIND_W-1:0] K_GT       = 6'd7;
	localparam logic [KIND_W-1:0] K_GE       = 6'd8;
	localparam logic [KIND_W-1:0] K_LE       = 6'd9;
	localparam logic [KIND_W-1:0] K_COLON    = 6'd10;
	localparam logic [KIND_W-1:0] K_NE       = 6'd11;
	localparam logic [KIND_W-1:0] K_SEMI     = 6'd12;
	localparam logic [KIND_W-1:0] K_LPAREN   = 6'd13;
	localparam logic [KIND_W-1:0] K_RPAREN   = 6'd14;
	localparam logic [KIND_W-1:0] K_COMMA    = 6'd15;
	localparam logic [KIND_W-1:0] K_CONCAT   = 6'd16;
	localparam logic [KIND_W-1:0] K_NOT      = 6'd17;
	localparam logic [KIND_W-1:0] K_LBRACE   = 6'd18;
	localparam logic [KIND_W-1:0] K_RBRACE   = 6'd19;
	localparam logic [KIND_W-1:0] K_IDENT    = 6'd20;
	localparam logic [KIND_W-1:0] K_CONST    = 6'd21;
	localparam logic [KIND_W-1:0] K_STRING   = 6'd22;
	localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd23;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_CHAR  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_IDENT = 2'd2;
	localparam logic [ERR_W-1:0] ERR_STR   = 2'd3;

	// keyword table, zero padded to the longest keyword
	localparam int KW_COUNT = 12;
	localparam int KW_MAX   = 10;

	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		6'd5, 6'd2, 6'd5, 6'd7, 6'd10, 6'd4, 6'd3, 6'd6, 6'd4, 6'd4, 6'd3, 6'd2
	};

	localparam logic [CHAR_W-1:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "c", "l", "a", "r", "e", 8'h00, 8'h00, 8'h00},
		'{"e", "n", "d", "d", "e", "c", "l", "a", "r", "e"},
		'{"r", "e", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// one scan result, from the scanner to the result register
	typedef struct packed {
		logic                hit;
		logic                tok;
		logic [KIND_W-1:0]   kind;
		logic [ERR_W-1:0]    err;
		logic [LINE_W-1:0]   line;
		logic [LEN_W-1:0]    len;
	} tdl_res_t;

endpackage

@@ hdl/table_driven_lexer.sv @@
// top level of the table-driven lexer: stream ports, input and result registers
// The lexer takes one source byte per clock and turns the stream into operator,
// identifier, constant, string and keyword tokens, skipping blanks and double-minus
// comments. A request is taken in every cycle the result side keeps up; a byte is
// held in the input register until the scanner steps on it, and its result, if any,
// is then loaded into the result register. The scanner state register is the only
// loop in the data path, so the rate is one byte per clock; only a stalled result
// register holds the input side back. Most tokens are reported when the byte after
// them arrives; an end marker (tlast) flushes the pending token. After any error
// result the block stays silent until reset. max_name_length is to be written
// through the cfg channel while the block is idle; the block does not enforce this.
module table_driven_lexer #(
	parameter int KEYWORD_CHARS = tdl_pkg::KEYWORD_CHARS_DEF,
	parameter int LINE_BITS     = tdl_pkg::LINE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// source bytes
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [tdl_pkg::CHAR_W-1:0] s_tdata,   // char_in
	input  logic                       s_tlast,   // is_end
	// results
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tdl_pkg::OUT_W-1:0]  m_tdata,   // token_kind, error_code, line_number,
	                                              // lexeme_length, zero fill
	output logic                       m_tuser,   // token_valid
	// length limit register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tdl_pkg::LEN_W-1:0]  cfg_data   // max_name_length
);
	import tdl_pkg::*;

	logic              v_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;
	logic              out_valid_q;
	tdl_res_t          res_q;
	tdl_res_t          res;
	logic [LEN_W-1:0]  max_len_q;
	logic              out_free, step, take;

	assign out_free  = !out_valid_q || m_tready;
	assign step      = v_s1 && out_free;
	assign s_tready  = !v_s1 || out_free;
	assign take      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// scanner
	tdl_scan #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.LINE_BITS    (LINE_BITS)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.char_in        (char_s1),
		.is_end         (end_s1),
		.max_name_length(max_len_q),
		.res            (res)
	);

	// control: stage valid, result valid, length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			max_len_q   <= MAX_LEN_RESET;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (step) begin
				v_s1 <= 1'b0;
			end
			if (step && res.hit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
		if (step && res.hit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.tok;
	assign m_tdata  = {2'b00, res_q.len, res_q.line, res_q.err, res_q.kind};

	// a result always carries a token or an error
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser || (m_tdata[7:6] != ERR_NONE)))
		else $error("result with neither token nor error");

	// no token means zero kind and zero length
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> ((m_tdata[5:0] == '0) && (m_tdata[29:24] == '0)))
		else $error("kind or length set without a token");

	// an error silences the block
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && (m_tdata[7:6] != ERR_NONE)) |=> !m_tvalid)
		else $error("result after an error");

endmodule

@@ hdl/tdl_kw_match.sv @@
// parallel compare of the stored identifier head against the keyword table
module tdl_kw_match #(
	parameter int KEYWORD_CHARS = tdl_pkg::KEYWORD_CHARS_DEF
) (
	input  logic [tdl_pkg::CHAR_W-1:0] name_bytes [KEYWORD_CHARS],
	input  logic [tdl_pkg::LEN_W-1:0]  name_length,
	output logic                       hit,
	output logic [tdl_pkg::KIND_W-1:0] kind
);
	import tdl_pkg::*;

	logic [KW_COUNT-1:0] match;

	// one comparator row per keyword, bytes past its length ignored
	always_comb begin
		for (int i = 0; i < KW_COUNT; i++) begin
			match[i] = (name_length == KW_LEN[i]);
			for (int j = 0; j < KW_MAX; j++) begin
				if ((j < int'(KW_LEN[i])) && (name_bytes[j] != KW_TEXT[i][j])) begin
					match[i] = 1'b0;
				end
			end
		end
	end

	// keywords are distinct, so at most one row matches
	always_comb begin
		hit  = |match;
		kind = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (match[i]) begin
				kind = K_KEYWORD0 + KIND_W'(i);
			end
		end
	end

endmodule

@@ hdl/tdl_scan.sv @@
// character-class automaton: scan state, counters and one-byte step logic
module tdl_scan #(
	parameter int KEYWORD_CHARS = tdl_pkg::KEYWORD_CHARS_DEF,
	parameter int LINE_BITS     = tdl_pkg::LINE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [tdl_pkg::CHAR_W-1:0] char_in,
	input  logic                       is_end,
	input  logic [tdl_pkg::LEN_W-1:0]  max_name_length,
	output tdl_pkg::tdl_res_t          res
);
	import tdl_pkg::*;

	localparam int IDX_W = $clog2(KEYWORD_CHARS);

	typedef enum logic [3:0] {
		ST_START, ST_IDENT, ST_INT, ST_FRAC, ST_STR, ST_STR_DONE, ST_DONE,
		ST_PLUS, ST_EQ, ST_LT, ST_GT, ST_BANG, ST_MINUS, ST_COMMENT, ST_DASH
	} state_t;

	state_t               state_q, state_d, cur;
	logic [KIND_W-1:0]    kind_q, kind_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic                 err_q, err_d;
	logic [CHAR_W-1:0]    name_q [KEYWORD_CHARS];

	logic                 letter, digit, ends, has_tok, emit;
	logic [ERR_W-1:0]     err;
	logic [LEN_W:0]       len_next;
	logic [LEN_W-1:0]     len_sat;
	logic                 nb_we;
	logic [IDX_W-1:0]     nb_idx;
	logic                 kw_hit;
	logic [KIND_W-1:0]    kw_kind, final_kind;
	logic [LINE_BITS+LINE_W-1:0] line_ext;

	// keyword lookup on the stored identifier head
	tdl_kw_match #(
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_kw (
		.name_bytes (name_q),
		.name_length(len_q),
		.hit        (kw_hit),
		.kind       (kw_kind)
	);

	assign final_kind = ((kind_q == K_IDENT) && kw_hit) ? kw_kind : kind_q;

	// character classes
	assign letter = (char_in inside {[8'h61:8'h7a], [8'h41:8'h5a]});
	assign digit  = (char_in inside {[8'h30:8'h39]});

	// does this byte close the pending token
	always_comb begin
		case (state_q)
			ST_IDENT:                    ends = !(letter || digit);
			ST_INT:                      ends = !(digit || (char_in == "."));
			ST_FRAC:                     ends = !digit;
			ST_STR_DONE, ST_DONE:        ends = 1'b1;
			ST_PLUS:                     ends = (char_in != "+");
			ST_EQ, ST_LT, ST_GT, ST_BANG: ends = (char_in != "=");
			ST_MINUS:                    ends = (char_in != "-");
			default:                     ends = 1'b0;
		endcase
	end

	assign has_tok  = !(state_q inside {ST_START, ST_COMMENT, ST_DASH});
	assign len_next = {1'b0, len_q} + 7'd1;
	assign len_sat  = (len_q == '1) ? len_q : len_next[LEN_W-1:0];

	// next state for one byte or an end marker
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		len_d   = len_q;
		line_d  = line_q;
		err_d   = err_q;
		emit    = 1'b0;
		err     = ERR_NONE;
		nb_we   = 1'b0;
		nb_idx  = len_q[IDX_W-1:0];
		cur     = state_q;
		if (!err_q) begin
			if (is_end) begin
				emit    = has_tok;
				state_d = ST_START;
			end else begin
				if (ends) begin
					emit = 1'b1;
					cur  = ST_START;
				end
				state_d = cur;
				case (cur)
					ST_START: begin
						if (letter) begin
							state_d = ST_IDENT;
							kind_d  = K_IDENT;
							len_d   = 6'd1;
							nb_we   = 1'b1;
							nb_idx  = '0;
						end else if (digit) begin
							state_d = ST_INT;
							kind_d  = K_CONST;
							len_d   = 6'd1;
						end else begin
							len_d = 6'd1;
							case (char_in)
								"\"": begin state_d = ST_STR;   kind_d = K_STRING; end
								"+":  begin state_d = ST_PLUS;  kind_d = K_ADD;    end
								"-":  begin state_d = ST_MINUS; kind_d = K_SUB;    end
								"*":  begin state_d = ST_DONE;  kind_d = K_MUL;    end
								"/":  begin state_d = ST_DONE;  kind_d = K_DIV;    end
								"=":  begin state_d = ST_EQ;    kind_d = K_ASSIGN; end
								"<":  begin state_d = ST_LT;    kind_d = K_LT;     end
								">":  begin state_d = ST_GT;    kind_d = K_GT;     end
								":":  begin state_d = ST_DONE;  kind_d = K_COLON;  end
								"!":  begin state_d = ST_BANG;  kind_d = K_NOT;    end
								";":  begin state_d = ST_DONE;  kind_d = K_SEMI;   end
								"(":  begin state_d = ST_DONE;  kind_d = K_LPAREN; end
								")":  begin state_d = ST_DONE;  kind_d = K_RPAREN; end
								",":  begin state_d = ST_DONE;  kind_d = K_COMMA;  end
								"{":  begin state_d = ST_DONE;  kind_d = K_LBRACE; end
								"}":  begin state_d = ST_DONE;  kind_d = K_RBRACE; end
								"?", "\t", " ": begin
									len_d = len_q;
								end
								"\n": begin
									len_d = len_q;
									if (line_q != '1) begin
										line_d = line_q + 1'b1;
									end
								end
								default: begin
									len_d = len_q;
									err   = ERR_CHAR;
								end
							endcase
						end
					end
					ST_IDENT: begin
						if (len_next > {1'b0, max_name_length}) begin
							err = ERR_IDENT;
						end else begin
							if (len_q < LEN_W'(KEYWORD_CHARS)) begin
								nb_we = 1'b1;
							end
							len_d = len_next[LEN_W-1:0];
						end
					end
					ST_INT: begin
						if (char_in == ".") begin
							state_d = ST_FRAC;
						end
						len_d = len_sat;
					end
					ST_FRAC: begin
						len_d = len_sat;
					end
					ST_STR: begin
						if (char_in == "\"") begin
							state_d = ST_STR_DONE;
						end else if (len_next > {1'b0, max_name_length}) begin
							err = ERR_STR;
						end else begin
							len_d = len_next[LEN_W-1:0];
						end
					end
					ST_PLUS: begin state_d = ST_DONE; kind_d = K_CONCAT; len_d = 6'd2; end
					ST_EQ:   begin state_d = ST_DONE; kind_d = K_EQUAL;  len_d = 6'd2; end
					ST_LT:   begin state_d = ST_DONE; kind_d = K_LE;     len_d = 6'd2; end
					ST_GT:   begin state_d = ST_DONE; kind_d = K_GE;     len_d = 6'd2; end
					ST_BANG: begin state_d = ST_DONE; kind_d = K_NE;     len_d = 6'd2; end
					ST_MINUS: state_d = ST_COMMENT;
					ST_COMMENT: begin
						if (char_in == "-") begin
							state_d = ST_DASH;
						end
					end
					ST_DASH: state_d = (char_in == "-") ? ST_COMMENT : ST_START;
					default: state_d = ST_START;
				endcase
				if (err != ERR_NONE) begin
					err_d   = 1'b1;
					state_d = ST_START;
				end
			end
		end
	end

	// low bits of the line counter, zero extended when it is narrow
	assign line_ext = (LINE_BITS + LINE_W)'(line_q);

	// result of this step
	always_comb begin
		res.hit  = emit || (err != ERR_NONE);
		res.tok  = emit;
		res.kind = emit ? final_kind : '0;
		res.err  = err;
		res.line = line_ext[LINE_W-1:0];
		res.len  = emit ? len_q : '0;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			kind_q  <= '0;
			len_q   <= '0;
			line_q  <= LINE_BITS'(1);
			err_q   <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			line_q  <= line_d;
			err_q   <= err_d;
		end
	end

	// identifier head bytes
	always_ff @(posedge clk) begin
		if (step && nb_we) begin
			name_q[nb_idx] <= char_in;
		end
	end

endmodule

@@ test/table_driven_lexer_tb.sv @@
// testbench for the table-driven lexer: scan predictor in a scoreboard, random source traffic
module table_driven_lexer_tb;
	import tdl_pkg::*;

	localparam int NAME_KEEP      = 10;
	localparam int LINE_SIZE      = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BYTES    = 105;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [LINE_W-1:0] LINE_TOP = 16'hFFFF;

	// scanner states of the automaton
	typedef enum logic [4:0] {
		ST_START, ST_NAME, ST_INT, ST_FRAC, ST_STR, ST_STR_DONE, ST_DONE, ST_PLUS,
		ST_EQ, ST_LT, ST_GT, ST_BANG, ST_MINUS, ST_COMMENT, ST_DASH
	} scan_t;

	typedef enum int {P_NAME, P_NUMBER, P_STRING, P_OPERATOR, P_COMMENT, P_BLANK, P_END} piece_t;

	typedef enum int {
		FAULT_TOKEN_AND_CHAR, FAULT_CHAR, FAULT_NAME_LONG, FAULT_STRING_LONG
	} fault_t;

	typedef struct packed {
		logic [LEN_W-1:0]                   limit;
		scan_t                              scan;
		logic [KIND_W-1:0]                  pend;
		logic [NAME_KEEP-1:0][CHAR_W-1:0]   name;
		logic [LEN_W-1:0]                   nlen;
		logic [LINE_SIZE-1:0]               line;
		logic                               err_seen;
	} lex_state_t;

	typedef struct packed {
		logic              tok;
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  err;
		logic [LINE_W-1:0] line;
		logic [LEN_W-1:0]  len;
	} lex_result_t;

	typedef struct packed {
		lex_result_t res;
		logic [63:0] stamp;
	} token_entry_t;

	// token predictor and queue of tokens still owed by the block
	class lex_scoreboard;
		lex_state_t   st;
		token_entry_t token_q[$];
		int           fails;

		function new();
			st = '0;
			st.limit = MAX_LEN_RESET;
			st.scan = ST_START;
			st.line = 1;
			fails = 0;
		endfunction

		function void set_limit(logic [LEN_W-1:0] v);
			st.limit = v;
		endfunction

		function string keyword(int i);
			case (i)
				0: return "while";
				1: return "if";
				2: return "const";
				3: return "declare";
				4: return "enddeclare";
				5: return "real";
				6: return "int";
				7: return "string";
				8: return "main";
				9: return "else";
				10: return "and";
				default: return "or";
			endcase
		endfunction

		function bit is_letter(logic [CHAR_W-1:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_digit(logic [CHAR_W-1:0] c);
			return c >= "0" && c <= "9";
		endfunction

		// identifiers whose text equals a keyword report the keyword code
		function logic [KIND_W-1:0] kind_of(lex_state_t s);
			string w;
			bit same;
			if (s.pend != K_IDENT)
				return s.pend;
			for (int i = 0; i < KW_COUNT; i++) begin
				w = keyword(i);
				if (w.len() == s.nlen && w.len() <= NAME_KEEP) begin
					same = 1;
					for (int j = 0; j < w.len(); j++)
						if (s.name[j] != w[j])
							same = 0;
					if (same)
						return KIND_W'(K_KEYWORD0 + i);
				end
			end
			return K_IDENT;
		endfunction

		function bit ends_token(scan_t s, logic [CHAR_W-1:0] c);
			case (s)
				ST_NAME: return !(is_letter(c) || is_digit(c));
				ST_INT: return !(is_digit(c) || c == ".");
				ST_FRAC: return !is_digit(c);
				ST_STR_DONE, ST_DONE: return 1;
				ST_PLUS: return c != "+";
				ST_EQ, ST_LT, ST_GT, ST_BANG: return c != "=";
				ST_MINUS: return c != "-";
				default: return 0;
			endcase
		endfunction

		function void open_token(inout lex_state_t s, input scan_t nxt_st,
		                         input logic [KIND_W-1:0] kind);
			s.scan = nxt_st;
			s.pend = kind;
			s.nlen = 1;
		endfunction

		function void pair_token(inout lex_state_t s, input logic [KIND_W-1:0] kind);
			s.scan = ST_DONE;
			s.pend = kind;
			s.nlen = 2;
		endfunction

		// one byte through the automaton, returns the error it raises
		function logic [ERR_W-1:0] advance(inout lex_state_t s, input logic [CHAR_W-1:0] c);
			int nxt;
			nxt = s.nlen + 1;
			case (s.scan)
				ST_START: begin
					if (is_letter(c)) begin
						open_token(s, ST_NAME, K_IDENT);
						s.name[0] = c;
					end else if (is_digit(c)) begin
						open_token(s, ST_INT, K_CONST);
					end else begin
						case (c)
							CH_QUOTE: open_token(s, ST_STR, K_STRING);
							"+": open_token(s, ST_PLUS, K_ADD);
							"-": open_token(s, ST_MINUS, K_SUB);
							"*": open_token(s, ST_DONE, K_MUL);
							"/": open_token(s, ST_DONE, K_DIV);
							"=": open_token(s, ST_EQ, K_ASSIGN);
							"<": open_token(s, ST_LT, K_LT);
							">": open_token(s, ST_GT, K_GT);
							":": open_token(s, ST_DONE, K_COLON);
							"!": open_token(s, ST_BANG, K_NOT);
							";": open_token(s, ST_DONE, K_SEMI);
							"(": open_token(s, ST_DONE, K_LPAREN);
							")": open_token(s, ST_DONE, K_RPAREN);
							",": open_token(s, ST_DONE, K_COMMA);
							"{": open_token(s, ST_DONE, K_LBRACE);
							"}": open_token(s, ST_DONE, K_RBRACE);
							"?", CH_TAB, " ": ;
							CH_LF: begin
								if (s.line != LINE_TOP)
									s.line = s.line + 1;
							end
							default: return ERR_CHAR;
						endcase
					end
				end
				ST_NAME: begin
					if (nxt > s.limit)
						return ERR_IDENT;
					if (s.nlen < NAME_KEEP)
						s.name[s.nlen] = c;
					s.nlen = LEN_W'(nxt);
				end
				ST_INT: begin
					if (c == ".")
						s.scan = ST_FRAC;
					if (s.nlen < 63)
						s.nlen = s.nlen + 1;
				end
				ST_FRAC: begin
					if (s.nlen < 63)
						s.nlen = s.nlen + 1;
				end
				ST_STR: begin
					if (c == CH_QUOTE)
						s.scan = ST_STR_DONE;
					else if (nxt > s.limit)
						return ERR_STR;
					else
						s.nlen = LEN_W'(nxt);
				end
				ST_PLUS: pair_token(s, K_CONCAT);
				ST_EQ: pair_token(s, K_EQUAL);
				ST_LT: pair_token(s, K_LE);
				ST_GT: pair_token(s, K_GE);
				ST_BANG: pair_token(s, K_NE);
				ST_MINUS: s.scan = ST_COMMENT;
				ST_COMMENT: begin
					if (c == "-")
						s.scan = ST_DASH;
				end
				ST_DASH: s.scan = (c == "-") ? ST_COMMENT : ST_START;
				default: s.scan = ST_START;
			endcase
			return ERR_NONE;
		endfunction

		// full step: token ended by this byte (or flushed by the end marker), plus error
		function void scan(inout lex_state_t s, input logic [CHAR_W-1:0] c, input logic last,
		                   output bit hit, output lex_result_t r);
			bit emit;
			logic [ERR_W-1:0] err;
			emit = 0;
			err = ERR_NONE;
			hit = 0;
			r = '0;
			if (s.err_seen)
				return;
			r.line = s.line;
			if (last) begin
				if (s.scan != ST_START && s.scan != ST_COMMENT && s.scan != ST_DASH) begin
					emit = 1;
					r.kind = kind_of(s);
					r.len = s.nlen;
				end
				s.scan = ST_START;
			end else begin
				if (ends_token(s.scan, c)) begin
					emit = 1;
					r.kind = kind_of(s);
					r.len = s.nlen;
					s.scan = ST_START;
				end
				err = advance(s, c);
				if (err != ERR_NONE) begin
					s.err_seen = 1;
					s.scan = ST_START;
				end
			end
			r.tok = emit;
			r.err = err;
			hit = emit || err != ERR_NONE;
		endfunction

		// error a byte would raise, without touching the live state
		function logic [ERR_W-1:0] peek_error(logic [CHAR_W-1:0] c);
			lex_state_t tmp;
			lex_result_t r;
			bit hit;
			tmp = st;
			scan(tmp, c, 1'b0, hit, r);
			return hit ? r.err : ERR_NONE;
		endfunction

		function void note_request(logic [CHAR_W-1:0] c, logic last);
			bit hit;
			lex_result_t r;
			token_entry_t e;
			scan(st, c, last, hit, r);
			if (hit) begin
				e.res = r;
				e.stamp = $time;
				token_q.push_back(e);
			end
		endfunction

		function int waiting();
			return token_q.size();
		endfunction

		task report(string what);
			fails++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(logic tok, logic [OUT_W-1:0] d);
			token_entry_t e;
			// a result can never come from a request taken at the same edge
			if (token_q.size() == 0 || token_q[0].stamp == $time) begin
				report($sformatf("result with none owed: tuser %b tdata %h", tok, d));
				return;
			end
			e = token_q.pop_front();
			if (tok !== e.res.tok)
				report($sformatf("token_valid %b, want %b", tok, e.res.tok));
			if (d[5:0] !== e.res.kind)
				report($sformatf("token_kind %0d, want %0d", d[5:0], e.res.kind));
			if (d[7:6] !== e.res.err)
				report($sformatf("error_code %0d, want %0d", d[7:6], e.res.err));
			if (d[23:8] !== e.res.line)
				report($sformatf("line_number %0d, want %0d", d[23:8], e.res.line));
			if (d[29:24] !== e.res.len)
				report($sformatf("lexeme_length %0d, want %0d", d[29:24], e.res.len));
			if (d[31:30] !== 2'b00)
				report($sformatf("fill bits %b not zero", d[31:30]));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [CHAR_W-1:0]   s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LEN_W-1:0]    cfg_data;

	lex_scoreboard sb;
	int  sent;
	int  stuck_cycles;
	bit  quiet;
	bit  hold_off;
	bit  errors_allowed;

	table_driven_lexer #(
		.KEYWORD_CHARS(NAME_KEEP),
		.LINE_BITS(LINE_SIZE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? CHAR_W'("a" + r) : CHAR_W'("A" + r - 26);
	endfunction

	// one source request; bytes that would trip the sticky error are swapped out unless errors are allowed
	task automatic feed(input logic [CHAR_W-1:0] c, input logic last);
		logic [CHAR_W-1:0] b;
		int gap;
		b = c;
		if (!last && !errors_allowed) begin
			if (sb.peek_error(b) != ERR_NONE)
				b = " ";
			if (sb.peek_error(b) != ERR_NONE)
				b = CH_QUOTE;
		end
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(b, last);
		sent++;
	endtask

	task automatic feed_text(input string t);
		for (int j = 0; j < t.len(); j++)
			feed(t[j], 1'b0);
	endtask

	// one random piece (lexeme, comment, blank or end marker), sometimes glued to the next one
	task automatic send_piece();
		string ops;
		logic [CHAR_W-1:0] sym;
		piece_t p;
		int r;
		int n;
		ops = "+-*/=<>:!;(),{}";
		r = $urandom_range(0, 99);
		if (r < 25)
			p = P_NAME;
		else if (r < 37)
			p = P_NUMBER;
		else if (r < 49)
			p = P_STRING;
		else if (r < 74)
			p = P_OPERATOR;
		else if (r < 80)
			p = P_COMMENT;
		else if (r < 95)
			p = P_BLANK;
		else
			p = P_END;
		case (p)
			P_NAME: begin
				if ($urandom_range(0, 2) == 0) begin
					feed_text(sb.keyword($urandom_range(0, KW_COUNT - 1)));
				end else begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
					feed(rand_letter(), 1'b0);
					repeat (n - 1)
						feed(($urandom_range(0, 3) == 0) ? CHAR_W'("0" + $urandom_range(0, 9))
						                                 : rand_letter(), 1'b0);
				end
			end
			P_NUMBER: begin
				n = ($urandom_range(0, 19) == 0) ? 70 : $urandom_range(1, 5);
				repeat (n)
					feed(CHAR_W'("0" + $urandom_range(0, 9)), 1'b0);
				if ($urandom_range(0, 4) < 2) begin
					feed(".", 1'b0);
					repeat ($urandom_range(0, 3))
						feed(CHAR_W'("0" + $urandom_range(0, 9)), 1'b0);
				end
			end
			P_STRING: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 62) : $urandom_range(0, 12);
				feed(CH_QUOTE, 1'b0);
				repeat (n)
					feed(CHAR_W'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 6) != 0)
					feed(CH_QUOTE, 1'b0);
			end
			P_OPERATOR: begin
				sym = ops[$urandom_range(0, ops.len() - 1)];
				feed(sym, 1'b0);
				r = $urandom_range(0, 9);
				if (r < 2)
					feed("=", 1'b0);
				else if (r < 4)
					feed(sym, 1'b0);
			end
			P_COMMENT: begin
				feed_text("--");
				repeat ($urandom_range(0, 8))
					feed(CHAR_W'($urandom_range(0, 255)), 1'b0);
				feed("-", 1'b0);
				feed(CHAR_W'($urandom_range(0, 255)), 1'b0);
			end
			P_BLANK: begin
				r = $urandom_range(0, 3);
				feed((r == 0) ? " " : (r == 1) ? CH_TAB : (r == 2) ? CH_LF : "?", 1'b0);
			end
			default: feed(CHAR_W'($urandom), 1'b1);
		endcase
		if ($urandom_range(0, 1) == 0)
			feed(" ", 1'b0);
	endtask

	// random stream, closed by an end marker so the scanner rests in its start state
	task automatic random_traffic(input int bytes);
		int first;
		first = sent;
		while (sent - first < bytes)
			send_piece();
		feed(CHAR_W'($urandom), 1'b1);
	endtask

	// wait until every owed token has come and the pipeline has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_limit(v);
	endtask

	// result side: random backpressure plus one long hold-off
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 0;
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// check accepted results
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// main sequence
	initial begin
		fault_t fault;
		logic [CHAR_W-1:0] b;
		int lim;
		sb = new();
		sent = 0;
		stuck_cycles = 0;
		quiet = 0;
		hold_off = 0;
		errors_allowed = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, byte extremes in a string flushed by the end marker,
		// comment and empty state at the end marker
		feed_text("++==!=<=>=<>!;(),{}*/:+-=");
		feed(CHAR_W'($urandom), 1'b1);
		feed(CH_QUOTE, 1'b0);
		feed(8'h00, 1'b0);
		feed(8'hFF, 1'b0);
		feed(CHAR_W'($urandom), 1'b1);
		feed_text("--x");
		feed(CHAR_W'($urandom), 1'b1);
		feed(CHAR_W'($urandom), 1'b1);
		settle();

		// widest limit, with the result side held off for a while
		write_limit(6'd63);
		hold_off = 1;
		random_traffic(PHASE_BYTES);
		settle();

		// narrowest limit
		write_limit(6'd1);
		random_traffic(PHASE_BYTES);
		settle();

		// keyword-sized limit, no idling on either side
		quiet = 1;
		write_limit(6'd10);
		random_traffic(PHASE_BYTES);
		settle();
		quiet = 0;

		write_limit(LEN_W'($urandom_range(2, 62)));
		random_traffic(PHASE_BYTES);
		settle();

		// one sticky error to close the run, then silence
		errors_allowed = 1;
		lim = sb.st.limit;
		fault = fault_t'($urandom_range(0, 3));
		case (fault)
			FAULT_TOKEN_AND_CHAR, FAULT_CHAR: begin
				if (fault == FAULT_TOKEN_AND_CHAR)
					feed_text("ab");
				do
					b = CHAR_W'($urandom_range(0, 255));
				while (sb.peek_error(b) != ERR_CHAR);
				feed(b, 1'b0);
			end
			FAULT_NAME_LONG: begin
				repeat (lim + 2) feed(rand_letter(), 1'b0);
			end
			default: begin
				feed(CH_QUOTE, 1'b0);
				repeat (lim + 2) feed("a", 1'b0);
			end
		endcase
		feed_text("a;+");
		feed(CHAR_W'($urandom), 1'b1);
		settle();

		if (sb.fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
